// File: src/hcc_pkg.sv
// hilbert curve codec package: widths, command codes, pipeline item types
// and the per-level walk function shared by the codec top level
// no dependencies
package hcc_pkg;

  localparam int MAX_LEVELS = 17;
  localparam int COORD_W    = 17;
  localparam int IDX_W      = 34;
  localparam int NOISE_W    = 32;
  localparam int LVL_W      = 5;
  localparam int SHIFT_W    = $clog2(MAX_LEVELS);
  localparam int NOISE_BITS = 17;

  localparam logic [NOISE_W-1:0] HASH_ADD = 32'h8000_0000;
  localparam logic [NOISE_W-1:0] HASH_MUL = 32'd2654435789;

  // level ranges walked by the three walk stages, msb first
  localparam int WALK_A_HI = MAX_LEVELS - 1;
  localparam int WALK_A_LO = (MAX_LEVELS * 2) / 3;
  localparam int WALK_B_HI = WALK_A_LO - 1;
  localparam int WALK_B_LO = MAX_LEVELS / 3;
  localparam int WALK_C_HI = WALK_B_LO - 1;
  localparam int WALK_C_LO = 0;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  // item in flight through the walk stages
  typedef struct packed {
    cmd_t                 cmd;
    logic [SHIFT_W-1:0]   shift;
    logic                 swap;
    logic                 flip;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [IDX_W-1:0]     idx;
  } item_t;

  // finished coordinates and index, before the hash
  typedef struct packed {
    logic [IDX_W-1:0]     idx;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
  } res_t;

  // walk levels hi down to lo; orientation travels as swap and flip bits
  function automatic item_t hcc_walk(item_t it, int hi, int lo);
    item_t o;
    logic  rx;
    logic  ry;
    logic  tx;
    logic  ty;
    o  = it;
    rx = 1'b0;
    ry = 1'b0;
    tx = 1'b0;
    ty = 1'b0;
    for (int n = MAX_LEVELS - 1; n >= 0; n--) begin
      if (n <= hi && n >= lo) begin
        if (o.cmd == CMD_ENCODE) begin
          tx = (o.swap ? o.y[n] : o.x[n]) ^ o.flip;
          ty = (o.swap ? o.x[n] : o.y[n]) ^ o.flip;
          rx = tx;
          ry = ty;
          o.idx[2*n +: 2] = {rx, rx ^ ry};
        end else begin
          rx = o.idx[2*n+1];
          ry = o.idx[2*n+1] ^ o.idx[2*n];
          tx = rx ^ o.flip;
          ty = ry ^ o.flip;
          o.x[n] = o.swap ? ty : tx;
          o.y[n] = o.swap ? tx : ty;
        end
        // quadrant rotation for the remaining lower levels
        if (!ry) begin
          o.flip = o.flip ^ rx;
          o.swap = !o.swap;
        end
      end
    end
    return o;
  endfunction

endpackage

// File: src/hcc_if.sv
// valid/ready channel interfaces of the hilbert curve codec:
// request items, response items and the level write channel
// depends on hcc_pkg
interface hcc_req_if import hcc_pkg::*; ();
  logic               valid;
  logic               ready;
  cmd_t               command;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [IDX_W-1:0]   curve_index;

  modport source (output valid, command, coord_x, coord_y, curve_index, input ready);
  modport sink   (input valid, command, coord_x, coord_y, curve_index, output ready);
endinterface

interface hcc_rsp_if import hcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   index_out;
  logic [COORD_W-1:0] x_out;
  logic [COORD_W-1:0] y_out;
  logic [NOISE_W-1:0] noise_value;

  modport source (output valid, index_out, x_out, y_out, noise_value, input ready);
  modport sink   (input valid, index_out, x_out, y_out, noise_value, output ready);
endinterface

interface hcc_cfg_if import hcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] hilbert_level;

  modport source (output valid, hilbert_level, input ready);
  modport sink   (input valid, hilbert_level, output ready);
endinterface

// File: src/hcc_noise.sv
// noise hash stage and response output register of the hilbert codec
// multiplies the low index bits by the hash constant; depends on hcc_pkg, hcc_if
module hcc_noise import hcc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  output logic             res_ready,
  input  res_t             res,
  hcc_rsp_if.source        rsp
);

  logic               valid;
  logic [NOISE_W-1:0] prod;
  logic [NOISE_W-1:0] noise_next;

  // output register frees up when empty or when its item is taken
  assign res_ready = !valid || rsp.ready;

  // multiplicative hash of the low index bits, kept to the word
  always_comb begin
    prod       = NOISE_W'(HASH_MUL * NOISE_W'(res.idx[NOISE_BITS-1:0]));
    noise_next = HASH_ADD + prod;
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_valid;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp.index_out   <= res.idx;
      rsp.x_out       <= res.x;
      rsp.y_out       <= res.y;
      rsp.noise_value <= noise_next;
    end
  end

  assign rsp.valid = valid;

endmodule

// File: src/hilbert_curve_codec_noise_core.sv
// hilbert curve codec with noise hash: throughput one item per cycle while the
// response side takes items; the level walk is split over three register
// stages and the hash multiply has a stage of its own.
// synchronous active-high reset empties the pipeline and sets the level to 17;
// stalls back up stage by stage, so bubbles still fill while the output waits
// depends on hcc_pkg, hcc_if, hcc_noise
module hilbert_curve_codec_noise_core import hcc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  hcc_req_if.sink    req,
  hcc_rsp_if.source  rsp,
  hcc_cfg_if.sink    cfg
);

  logic [LVL_W-1:0]   level;
  logic [LVL_W-1:0]   eff_level;
  logic [SHIFT_W-1:0] shift;
  item_t              in_item;

  logic [3:0]         stg_v;
  logic [3:0]         stg_rdy;
  item_t              stg_d [4];
  item_t              stg_next [4];

  logic               res_v;
  logic               res_rdy;
  res_t               res_d;
  res_t               res_next;
  logic               noise_rdy;

  // level register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= LVL_W'(MAX_LEVELS);
    end else if (cfg.valid) begin
      level <= cfg.hilbert_level;
    end
  end

  // clamp level and align the used bits to the top of the walk
  always_comb begin
    if (level == '0) begin
      eff_level = LVL_W'(1);
    end else if (level > LVL_W'(MAX_LEVELS)) begin
      eff_level = LVL_W'(MAX_LEVELS);
    end else begin
      eff_level = level;
    end
    shift = SHIFT_W'(LVL_W'(MAX_LEVELS) - eff_level);
  end

  always_comb begin
    in_item       = '0;
    in_item.cmd   = req.command;
    in_item.shift = shift;
    if (req.command == CMD_ENCODE) begin
      in_item.x = COORD_W'(req.coord_x << shift);
      in_item.y = COORD_W'(req.coord_y << shift);
    end else begin
      in_item.idx = IDX_W'(req.curve_index << {shift, 1'b0});
    end
  end

  // backpressure chain
  always_comb begin
    res_rdy    = !res_v || noise_rdy;
    stg_rdy[3] = !stg_v[3] || res_rdy;
    for (int i = 2; i >= 0; i--) begin
      stg_rdy[i] = !stg_v[i] || stg_rdy[i+1];
    end
  end

  assign req.ready = stg_rdy[0];

  // next values of the walk stages
  always_comb begin
    stg_next[0] = in_item;
    stg_next[1] = hcc_walk(stg_d[0], WALK_A_HI, WALK_A_LO);
    stg_next[2] = hcc_walk(stg_d[1], WALK_B_HI, WALK_B_LO);
    stg_next[3] = hcc_walk(stg_d[2], WALK_C_HI, WALK_C_LO);
  end

  // shift the results back down to the used bits
  always_comb begin
    res_next.idx = stg_d[3].idx >> {stg_d[3].shift, 1'b0};
    res_next.x   = stg_d[3].x >> stg_d[3].shift;
    res_next.y   = stg_d[3].y >> stg_d[3].shift;
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_v <= '0;
      res_v <= 1'b0;
    end else begin
      if (stg_rdy[0]) begin
        stg_v[0] <= req.valid;
      end
      for (int i = 1; i < 4; i++) begin
        if (stg_rdy[i]) begin
          stg_v[i] <= stg_v[i-1];
        end
      end
      if (res_rdy) begin
        res_v <= stg_v[3];
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (stg_rdy[0] && req.valid) begin
      stg_d[0] <= stg_next[0];
    end
    for (int i = 1; i < 4; i++) begin
      if (stg_rdy[i] && stg_v[i-1]) begin
        stg_d[i] <= stg_next[i];
      end
    end
    if (res_rdy && stg_v[3]) begin
      res_d <= res_next;
    end
  end

  // hash and output register
  hcc_noise u_noise (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_v),
    .res_ready (noise_rdy),
    .res       (res_d),
    .rsp       (rsp)
  );

endmodule

// File: tb/tb_top.sv
// self-checking testbench for hilbert_curve_codec_noise_core: random and directed
// encode/decode items at several levels, results checked against a local codec model
// depends on hcc_pkg, hcc_if and the codec core
module tb_top;
  import hcc_pkg::*;

  localparam int          IDLE_MAX    = 18;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          HOLD_CYCLES = 200;
  localparam int          DRAIN_WAIT  = 12;
  localparam int          REPORT_MAX  = 10;
  localparam logic [63:0] KNUTH_ADD   = 64'h8000_0000;
  localparam logic [63:0] KNUTH_MUL   = 64'd2654435789;
  localparam logic [COORD_W-1:0] COORD_ONES = '1;
  localparam logic [IDX_W-1:0]   INDEX_ONES = '1;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [NOISE_W-1:0] noise;
  } codec_result_t;

  logic clk = 1'b0;
  logic rst;

  hcc_req_if req_ch ();
  hcc_rsp_if rsp_ch ();
  hcc_cfg_if cfg_ch ();

  hilbert_curve_codec_noise_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  codec_result_t    awaited_results[$];
  logic [LVL_W-1:0] level_shadow;
  int               mismatches;
  int               results_seen;
  bit               tx_idle;
  bit               rx_idle;
  int               stall_cycles;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // expected codec output for one item at the given level register value
  function automatic codec_result_t hilbert_codec(cmd_t c, logic [COORD_W-1:0] cx,
                                                  logic [COORD_W-1:0] cy,
                                                  logic [IDX_W-1:0] ci,
                                                  logic [LVL_W-1:0] lvl);
    codec_result_t r;
    int            lv;
    int            n;
    logic [63:0]   x;
    logic [63:0]   y;
    logic [63:0]   d;
    logic [63:0]   i;
    logic [63:0]   t;
    logic [63:0]   mk;
    logic [63:0]   rx;
    logic [63:0]   ry;
    logic [63:0]   prod;
    lv = int'(lvl);
    if (lv < 1) lv = 1;
    if (lv > MAX_LEVELS) lv = MAX_LEVELS;
    if (c == CMD_ENCODE) begin
      x = {47'd0, cx} & ((64'd1 << lv) - 64'd1);
      y = {47'd0, cy} & ((64'd1 << lv) - 64'd1);
      r.x = x[COORD_W-1:0];
      r.y = y[COORD_W-1:0];
      d = 64'd0;
      // walk from the top level down, rotating the lower quadrant
      for (int k = 0; k < lv; k++) begin
        n  = lv - k - 1;
        rx = (x >> n) & 64'd1;
        ry = (y >> n) & 64'd1;
        d  = d | (((64'd3 * rx) ^ ry) << (2 * n));
        if (ry == 64'd0) begin
          if (rx == 64'd1) begin
            mk = (64'd1 << n) - 64'd1;
            x  = (x ^ mk) & mk;
            y  = (y ^ mk) & mk;
          end
          t = x;
          x = y;
          y = t;
        end
      end
    end else begin
      i = {30'd0, ci} & ((64'd1 << (2 * lv)) - 64'd1);
      d = i;
      x = 64'd0;
      y = 64'd0;
      // walk from the bottom level up, unrotating as bits are added
      for (int k = 0; k < lv; k++) begin
        rx = (i >> 1) & 64'd1;
        ry = (i ^ (i >> 1)) & 64'd1;
        if (ry == 64'd0) begin
          if (rx == 64'd1) begin
            mk = (64'd1 << k) - 64'd1;
            x  = mk - x;
            y  = mk - y;
          end
          t = x;
          x = y;
          y = t;
        end
        x = x + (rx << k);
        y = y + (ry << k);
        i = i >> 2;
      end
      r.x = x[COORD_W-1:0];
      r.y = y[COORD_W-1:0];
    end
    r.idx   = d[IDX_W-1:0];
    prod    = KNUTH_ADD + KNUTH_MUL * {47'd0, d[NOISE_BITS-1:0]};
    r.noise = prod[NOISE_W-1:0];
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = COORD_ONES;
      1:       v = '0;
      default: v = COORD_W'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0:       v = {30'd0, INDEX_ONES};
      1:       v = 64'd0;
      default: v = {$urandom(), $urandom()};
    endcase
    return v[IDX_W-1:0];
  endfunction

  // offer one item after a random gap, record its expected result on accept
  task automatic send_item(cmd_t c, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [IDX_W-1:0] ci);
    int gap;
    gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.command     = c;
    req_ch.coord_x     = x;
    req_ch.coord_y     = y;
    req_ch.curve_index = ci;
    req_ch.valid       = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    awaited_results.push_back(hilbert_codec(c, x, y, ci, level_shadow));
  endtask

  task automatic send_random(int count);
    repeat (count) begin
      send_item(cmd_t'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_index());
    end
  endtask

  // stop offering and wait until every expected result has arrived
  task automatic wait_results_done();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_level(logic [LVL_W-1:0] value);
    wait_results_done();
    @(negedge clk);
    cfg_ch.hilbert_level = value;
    cfg_ch.valid         = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    level_shadow = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // corners, bit patterns, unused fields and out-of-range levels
  task automatic test_directed();
    send_item(CMD_ENCODE, '0, '0, rand_index());
    send_item(CMD_ENCODE, COORD_ONES, COORD_ONES, rand_index());
    send_item(CMD_ENCODE, COORD_ONES, '0, rand_index());
    send_item(CMD_ENCODE, '0, COORD_ONES, rand_index());
    send_item(CMD_ENCODE, 17'h15555, 17'h0AAAA, rand_index());
    send_item(CMD_ENCODE, 17'd1, 17'd0, rand_index());
    send_item(CMD_ENCODE, 17'd0, 17'd1, rand_index());
    send_item(CMD_DECODE, rand_coord(), rand_coord(), '0);
    send_item(CMD_DECODE, rand_coord(), rand_coord(), INDEX_ONES);
    send_item(CMD_DECODE, rand_coord(), rand_coord(), 34'h2_AAAA_AAAA);
    send_item(CMD_DECODE, rand_coord(), rand_coord(), 34'h1_5555_5555);
    send_item(CMD_DECODE, rand_coord(), rand_coord(), 34'd1);
    send_item(CMD_DECODE, rand_coord(), rand_coord(), 34'd2);
    send_item(CMD_DECODE, rand_coord(), rand_coord(), 34'd3);
    // level zero behaves as a single level
    write_level(5'd0);
    send_item(CMD_ENCODE, COORD_ONES, COORD_ONES, rand_index());
    send_item(CMD_ENCODE, 17'd1, 17'd0, rand_index());
    send_item(CMD_DECODE, rand_coord(), rand_coord(), INDEX_ONES);
    send_item(CMD_DECODE, rand_coord(), rand_coord(), 34'd2);
    // levels above the maximum saturate
    write_level(5'd31);
    send_item(CMD_ENCODE, COORD_ONES, 17'h0F0F0, rand_index());
    send_item(CMD_DECODE, rand_coord(), rand_coord(), 34'h3_0000_0003);
    write_level(5'd1);
    send_item(CMD_ENCODE, COORD_ONES, COORD_ONES, rand_index());
    send_item(CMD_DECODE, rand_coord(), rand_coord(), INDEX_ONES);
  endtask

  // random items over a sweep of level settings
  task automatic test_level_sweep();
    logic [LVL_W-1:0] levels[10];
    levels = '{5'd17, 5'd1, 5'd2, 5'd3, 5'd0, 5'd31, 5'd8, 5'd16, 5'd0, 5'd0};
    levels[8] = LVL_W'($urandom_range(0, 31));
    levels[9] = LVL_W'($urandom_range(0, 31));
    foreach (levels[p]) begin
      write_level(levels[p]);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      send_random(52);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_output_hold();
    write_level(5'd17);
    tx_idle = 1'b0;
    @(negedge clk);
    stall_cycles = HOLD_CYCLES;
    send_random(40);
    tx_idle = 1'b1;
  endtask

  // sender pauses until the pipeline is empty, then resumes
  task automatic test_sender_pause();
    write_level(5'd12);
    send_random(20);
    wait_results_done();
    send_random(20);
  endtask

  // back-to-back items with both sides always ready
  task automatic test_full_rate();
    write_level(5'd17);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_random(50);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // response ready with random gaps and an on-demand long hold
  initial begin : response_sink
    int gap;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(negedge clk);
      gap = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
      gap = gap + stall_cycles;
      stall_cycles = 0;
      if (gap > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid && stall_cycles == 0) @(posedge clk);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    codec_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result %0d: unexpected, got idx %h x %h y %h noise %h", results_seen,
                   rsp_ch.index_out, rsp_ch.x_out, rsp_ch.y_out, rsp_ch.noise_value);
      end else begin
        want = awaited_results.pop_front();
        if (rsp_ch.index_out !== want.idx || rsp_ch.x_out !== want.x ||
            rsp_ch.y_out !== want.y || rsp_ch.noise_value !== want.noise) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result %0d: expected idx %h x %h y %h noise %h, got idx %h x %h y %h noise %h",
                     results_seen, want.idx, want.x, want.y, want.noise, rsp_ch.index_out,
                     rsp_ch.x_out, rsp_ch.y_out, rsp_ch.noise_value);
        end
      end
    end
  end

  // end the run if no handshake completes for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("hilbert_curve_codec_noise_core: mismatch");
    $finish;
  end

  // test sequence
  initial begin : main_seq
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.command       = CMD_ENCODE;
    req_ch.coord_x       = '0;
    req_ch.coord_y       = '0;
    req_ch.curve_index   = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.hilbert_level = '0;
    level_shadow         = 5'd17;
    mismatches           = 0;
    results_seen         = 0;
    tx_idle              = 1'b1;
    rx_idle              = 1'b1;
    stall_cycles         = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_level_sweep();
    test_output_hold();
    test_sender_pause();
    test_full_rate();

    wait_results_done();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0)
      $display("hilbert_curve_codec_noise_core: match");
    else
      $display("hilbert_curve_codec_noise_core: mismatch");
    $finish;
  end

endmodule

// File: files.f
src/hcc_pkg.sv
src/hcc_if.sv
src/hcc_noise.sv
src/hilbert_curve_codec_noise_core.sv
tb/tb_top.sv
